// File: src/bsr_pkg.sv
// Package of the ball span rasterizer: beat payload types, register indexes,
// command and status codes, and the sequencer state type.
// Depends on nothing; ball_span_rasterizer.sv imports it.
package bsr_pkg;

  localparam int COORD_W = 12;  // width of every coordinate field on the ports
  localparam int RAD_W   = 12;  // radius field, unsigned fixed point
  localparam int LBL_W   = 8;
  localparam int REG_W   = 13;  // size registers
  localparam int IDX_W   = 2;   // register index on the configuration port

  localparam logic [REG_W-1:0] SIZE_RESET = 13'd4096;

  localparam logic [IDX_W-1:0] REG_IMG_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_IMG_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_IMG_DEPTH  = 2'd2;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic STAT_SPAN = 1'b0;
  localparam logic STAT_OOB  = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [COORD_W-1:0] center_x;
    logic [COORD_W-1:0] center_y;
    logic [COORD_W-1:0] center_z;
    logic [RAD_W-1:0]   radius;
    logic [LBL_W-1:0]   label;
  } in_item_t;

  typedef struct packed {
    logic               status;
    logic [COORD_W-1:0] span_z;
    logic [COORD_W-1:0] span_y;
    logic [COORD_W-1:0] x_start;
    logic [COORD_W-1:0] x_end;
    logic [LBL_W-1:0]   fill_label;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [REG_W-1:0] wdata;
  } cfg_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD_SQ,
    ST_LOAD_R2,
    ST_TICK_Z,
    ST_TICK_Y,
    ST_TICK_B,
    ST_ROOT,
    ST_ROOT_DONE,
    ST_SEEK_Z,
    ST_SLICE_A,
    ST_SEEK_Y,
    ST_ROW_B,
    ST_EMIT
  } bsr_state_e;

endpackage

// File: src/bsr_stream_if.sv
// Valid/ready channel carrying one payload per beat, used for the item,
// result and configuration channels. The payload type is set per instance.
interface bsr_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/ball_span_rasterizer.sv
// Top level of the ball span rasterizer: sequencer, shared squarer and
// shared digit-by-digit square root unit. Uses bsr_pkg and bsr_stream_if.
//
// A load beat (cmd 0) takes a ball center, a Q8.4 radius and a label; a center
// outside the volume returns one beat with status 1, otherwise nothing. Each
// tick beat (cmd 1) then returns the next row span of the ball in slice-major,
// row-minor order, with last set on the final span; a tick with no ball pending
// returns nothing. The block takes one beat at a time. A load squares the radius
// and then seeks the first span; a tick squares the slice and row offsets, takes
// the square root for the row half-width, seeks the next span and hands over
// the result. The seek tests slices and rows in turn and must find the row
// half-width of each slice it enters; every square root goes through the one root
// unit at two bits a cycle, on a 24-bit radicand. Size registers may be written
// whenever item_i is ready and no item beat is offered; the sizes in force when
// a beat is taken apply to it.
module ball_span_rasterizer #(
  parameter int COORD_BITS       = 12,
  parameter int RADIUS_FRAC_BITS = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  bsr_stream_if.sink   item_i,
  bsr_stream_if.source span_o,
  bsr_stream_if.sink   cfg_i
);
  import bsr_pkg::*;

  localparam int CB     = COORD_BITS;
  localparam int F      = RADIUS_FRAC_BITS;
  localparam int RRW    = RAD_W + 1;
  localparam int EW     = ((CB > RRW) ? CB : RRW) + 2;
  localparam int OPW    = RAD_W + 1;
  localparam int SQW    = 2 * OPW;
  localparam int AW     = SQW + 1;
  localparam int R2W    = 2 * RAD_W;
  localparam int REM_W  = RAD_W + 3;
  localparam int CNT_W  = $clog2(RAD_W + 1);
  localparam int HALF    = (1 << F) >> 1;
  localparam int CAP_VAL = 1 << CB;

  bsr_state_e state_q, state_d;
  logic busy_q, busy_d;
  logic out_valid_q, out_valid_d;
  logic tick_q, tick_d;
  logic root_x_q, root_x_d;

  logic [REG_W-1:0] img_w_q, img_h_q, img_d_q;
  logic [CB-1:0]    ball_x_q, ball_x_d, ball_y_q, ball_y_d, ball_z_q, ball_z_d;
  logic [RAD_W-1:0] ball_r_q, ball_r_d;
  logic [LBL_W-1:0] ball_lbl_q, ball_lbl_d;
  logic [CB-1:0]    cur_z_q, cur_z_d, cur_y_q, cur_y_d;

  logic signed [EW-1:0] z_q, z_d, y_q, y_d, ye_q, ye_d;
  logic [R2W-1:0]       r2_q, r2_d;
  logic signed [AW-1:0] a_q, a_d;
  logic [SQW-1:0]       sq_q, sq_d;
  logic [OPW-1:0]       sq_op;
  logic [R2W-1:0]       rad_q, rad_d;
  logic [REM_W-1:0]     rem_q, rem_d;
  logic [RAD_W-1:0]     root_q, root_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  out_item_t            pend_q, pend_d, out_q, out_d;

  // Derived geometry.
  logic signed [EW-1:0] wmax, hmax, dmax;
  logic signed [EW-1:0] cx_e, cy_e, cz_e;
  logic [RRW-1:0]       rz, rr;
  logic signed [EW-1:0] rz_e, rr_e;
  logic signed [EW-1:0] zs_raw, zs, ze_raw, ze;
  logic signed [EW-1:0] dz, dz_abs, dy, dy_abs;
  logic [OPW-1:0]       op_z, op_y;
  logic signed [AW-1:0] a_new, b_new;
  logic signed [EW-1:0] ys_raw, ye_raw, xs_raw, xs, xe_raw, xe_min, xe;
  logic [REM_W-1:0]     rem_sh, trial;
  logic signed [EW-1:0] in_cx_e, in_cy_e, in_cz_e;
  logic                 in_oob;

  function automatic logic signed [EW-1:0] size_lim(input logic [REG_W-1:0] r);
    logic signed [EW-1:0] v;
    logic signed [EW-1:0] cap;
    v   = EW'(r);
    cap = EW'(CAP_VAL);
    return (v > cap) ? cap : v;
  endfunction

  assign wmax = size_lim(img_w_q) - EW'(1);
  assign hmax = size_lim(img_h_q) - EW'(1);
  assign dmax = size_lim(img_d_q) - EW'(1);

  assign cx_e = EW'(ball_x_q);
  assign cy_e = EW'(ball_y_q);
  assign cz_e = EW'(ball_z_q);

  // Radius and row half-widths rounded half away from zero.
  assign rz   = RRW'((RRW'(ball_r_q) + RRW'(HALF)) >> F);
  assign rr   = RRW'((RRW'(root_q) + RRW'(HALF)) >> F);
  assign rz_e = EW'(rz);
  assign rr_e = EW'(rr);

  assign zs_raw = cz_e - rz_e;
  assign zs     = (zs_raw < 0) ? '0 : zs_raw;
  assign ze_raw = cz_e + rz_e;
  assign ze     = (ze_raw > dmax) ? dmax : ze_raw;

  // Offsets scaled by 2^F stay below 2^13 for any slice or row in range.
  assign dz     = z_q - cz_e;
  assign dz_abs = (dz < 0) ? -dz : dz;
  assign op_z   = OPW'(dz_abs << F);
  assign dy     = y_q - cy_e;
  assign dy_abs = (dy < 0) ? -dy : dy;
  assign op_y   = OPW'(dy_abs << F);

  assign sq_d  = SQW'(sq_op) * SQW'(sq_op);
  assign a_new = $signed(AW'(r2_q)) - $signed(AW'(sq_q));
  assign b_new = a_q - $signed(AW'(sq_q));

  assign ys_raw = cy_e - rr_e;
  assign ye_raw = cy_e + rr_e;
  assign xs_raw = cx_e - rr_e;
  assign xs     = (xs_raw < 0) ? '0 : xs_raw;
  assign xe_raw = cx_e + rr_e;
  assign xe_min = (xe_raw > wmax) ? wmax : xe_raw;
  assign xe     = (xe_min < 0) ? '0 : xe_min;

  // One step of the restoring square root: bring down two radicand bits.
  assign rem_sh = {rem_q[REM_W-3:0], rad_q[R2W-1 -: 2]};
  assign trial  = REM_W'({root_q, 2'b01});

  assign in_cx_e = EW'(CB'(item_i.data.center_x));
  assign in_cy_e = EW'(CB'(item_i.data.center_y));
  assign in_cz_e = EW'(CB'(item_i.data.center_z));
  assign in_oob  = (in_cx_e > wmax) || (in_cy_e > hmax) || (in_cz_e > dmax);

  assign item_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready  = 1'b1;
  assign span_o.valid = out_valid_q;
  assign span_o.data  = out_q;

  always_comb begin
    state_d     = state_q;
    busy_d      = busy_q;
    out_valid_d = out_valid_q && !span_o.ready;
    tick_d      = tick_q;
    root_x_d    = root_x_q;
    ball_x_d    = ball_x_q;
    ball_y_d    = ball_y_q;
    ball_z_d    = ball_z_q;
    ball_r_d    = ball_r_q;
    ball_lbl_d  = ball_lbl_q;
    cur_z_d     = cur_z_q;
    cur_y_d     = cur_y_q;
    z_d         = z_q;
    y_d         = y_q;
    ye_d        = ye_q;
    r2_d        = r2_q;
    a_d         = a_q;
    rad_d       = rad_q;
    rem_d       = rem_q;
    root_d      = root_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    out_d       = out_q;
    sq_op       = '0;

    case (state_q)
      ST_IDLE: begin
        if (item_i.valid) begin
          if (item_i.data.cmd == CMD_LOAD) begin
            busy_d = 1'b0;
            if (in_oob) begin
              pend_d        = '0;
              pend_d.status = STAT_OOB;
              state_d       = ST_EMIT;
            end else begin
              ball_x_d   = CB'(item_i.data.center_x);
              ball_y_d   = CB'(item_i.data.center_y);
              ball_z_d   = CB'(item_i.data.center_z);
              ball_r_d   = item_i.data.radius;
              ball_lbl_d = item_i.data.label;
              state_d    = ST_LOAD_SQ;
            end
          end else if (busy_q) begin
            z_d               = EW'(cur_z_q);
            y_d               = EW'(cur_y_q);
            pend_d            = '0;
            pend_d.status     = STAT_SPAN;
            pend_d.span_z     = COORD_W'(cur_z_q);
            pend_d.span_y     = COORD_W'(cur_y_q);
            pend_d.fill_label = ball_lbl_q;
            tick_d            = 1'b1;
            state_d           = ST_TICK_Z;
          end
        end
      end

      ST_LOAD_SQ: begin
        sq_op   = OPW'(ball_r_q);
        state_d = ST_LOAD_R2;
      end

      ST_LOAD_R2: begin
        r2_d    = sq_q[R2W-1:0];
        z_d     = zs;
        y_d     = '0;
        tick_d  = 1'b0;
        state_d = ST_SEEK_Z;
      end

      ST_TICK_Z: begin
        sq_op   = op_z;
        state_d = ST_TICK_Y;
      end

      ST_TICK_Y: begin
        a_d     = a_new;
        sq_op   = op_y;
        state_d = ST_TICK_B;
      end

      ST_TICK_B: begin
        rad_d    = (b_new < 0) ? '0 : b_new[R2W-1:0];
        rem_d    = '0;
        root_d   = '0;
        cnt_d    = '0;
        root_x_d = 1'b1;
        state_d  = ST_ROOT;
      end

      ST_ROOT: begin
        if (rem_sh >= trial) begin
          rem_d  = rem_sh - trial;
          root_d = {root_q[RAD_W-2:0], 1'b1};
        end else begin
          rem_d  = rem_sh;
          root_d = {root_q[RAD_W-2:0], 1'b0};
        end
        rad_d = rad_q << 2;
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(RAD_W - 1)) begin
          state_d = ST_ROOT_DONE;
        end
      end

      ST_ROOT_DONE: begin
        if (root_x_q) begin
          // Span of the current row is done; look for the one after it.
          pend_d.x_start = COORD_W'(xs);
          pend_d.x_end   = COORD_W'(xe);
          y_d            = y_q + EW'(1);
          state_d        = ST_SEEK_Z;
        end else begin
          ye_d = (ye_raw > hmax) ? hmax : ye_raw;
          if (y_q < ys_raw) begin
            y_d = (ys_raw < 0) ? '0 : ys_raw;
          end
          state_d = ST_SEEK_Y;
        end
      end

      ST_SEEK_Z: begin
        if (z_q > ze) begin
          busy_d      = 1'b0;
          pend_d.last = 1'b1;
          state_d     = tick_q ? ST_EMIT : ST_IDLE;
        end else begin
          sq_op   = op_z;
          state_d = ST_SLICE_A;
        end
      end

      ST_SLICE_A: begin
        a_d = a_new;
        if (a_new < 0) begin
          z_d     = z_q + EW'(1);
          y_d     = '0;
          state_d = ST_SEEK_Z;
        end else begin
          rad_d    = a_new[R2W-1:0];
          rem_d    = '0;
          root_d   = '0;
          cnt_d    = '0;
          root_x_d = 1'b0;
          state_d  = ST_ROOT;
        end
      end

      ST_SEEK_Y: begin
        if (y_q > ye_q) begin
          z_d     = z_q + EW'(1);
          y_d     = '0;
          state_d = ST_SEEK_Z;
        end else begin
          sq_op   = op_y;
          state_d = ST_ROW_B;
        end
      end

      ST_ROW_B: begin
        if (b_new >= 0) begin
          busy_d      = 1'b1;
          cur_z_d     = CB'(z_q);
          cur_y_d     = CB'(y_q);
          pend_d.last = 1'b0;
          state_d     = tick_q ? ST_EMIT : ST_IDLE;
        end else begin
          y_d     = y_q + EW'(1);
          state_d = ST_SEEK_Y;
        end
      end

      ST_EMIT: begin
        if (!out_valid_q || span_o.ready) begin
          out_valid_d = 1'b1;
          out_d       = pend_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      tick_q      <= 1'b0;
      root_x_q    <= 1'b0;
      img_w_q     <= SIZE_RESET;
      img_h_q     <= SIZE_RESET;
      img_d_q     <= SIZE_RESET;
      ball_x_q    <= '0;
      ball_y_q    <= '0;
      ball_z_q    <= '0;
      ball_r_q    <= '0;
      ball_lbl_q  <= '0;
      cur_z_q     <= '0;
      cur_y_q     <= '0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      tick_q      <= tick_d;
      root_x_q    <= root_x_d;
      ball_x_q    <= ball_x_d;
      ball_y_q    <= ball_y_d;
      ball_z_q    <= ball_z_d;
      ball_r_q    <= ball_r_d;
      ball_lbl_q  <= ball_lbl_d;
      cur_z_q     <= cur_z_d;
      cur_y_q     <= cur_y_d;
      cnt_q       <= cnt_d;
      if (cfg_i.valid) begin
        case (cfg_i.data.idx)
          REG_IMG_WIDTH:  img_w_q <= cfg_i.data.wdata;
          REG_IMG_HEIGHT: img_h_q <= cfg_i.data.wdata;
          REG_IMG_DEPTH:  img_d_q <= cfg_i.data.wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    z_q    <= z_d;
    y_q    <= y_d;
    ye_q   <= ye_d;
    r2_q   <= r2_d;
    a_q    <= a_d;
    sq_q   <= sq_d;
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

endmodule
